// ===== hw/rtl/fsme_pkg.sv =====
// shared types, codes and defaults of the table-driven state machine engine
`timescale 1ns / 1ps

package fsme_pkg;

	// fixed field widths on the ports
	localparam int FUNC_BITS   = 2;
	localparam int FIELD_BITS  = 8;
	localparam int STATUS_BITS = 2;

	// configuration port geometry
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	// register index taken from paddr[2]
	localparam logic REG_INITIAL_STATE = 1'b0;

	// parameter defaults
	localparam int DEF_STATE_BITS      = 8;
	localparam int DEF_SIGNAL_BITS     = 8;
	localparam int DEF_REGULAR_ENTRIES = 64;
	localparam int DEF_ERROR_ENTRIES   = 16;

	// command codes
	localparam logic [FUNC_BITS-1:0] FN_ADD_REG = 2'd0;
	localparam logic [FUNC_BITS-1:0] FN_ADD_ERR = 2'd1;
	localparam logic [FUNC_BITS-1:0] FN_DELIVER = 2'd2;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 2'd0,
		ST_NOMATCH = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_ERR  = 3'b010,
		S_REG  = 3'b100
	} seq_state_t;

	// configuration write toward the sequencer
	typedef struct packed {
		logic                  load;
		logic [FIELD_BITS-1:0] value;
	} cfg_load_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic busy;
		logic reg_full;
		logic err_full;
	} seq_stat_t;

endpackage

// ===== hw/rtl/fsme_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read port
`timescale 1ns / 1ps

module fsme_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/fsme_seq.sv =====
// command sequencer: table appends, error and regular table scans, result strobe
`timescale 1ns / 1ps

module fsme_seq #(
	parameter int STATE_BITS      = fsme_pkg::DEF_STATE_BITS,
	parameter int SIGNAL_BITS     = fsme_pkg::DEF_SIGNAL_BITS,
	parameter int REGULAR_ENTRIES = fsme_pkg::DEF_REGULAR_ENTRIES,
	parameter int ERROR_ENTRIES   = fsme_pkg::DEF_ERROR_ENTRIES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [fsme_pkg::FUNC_BITS-1:0]      func,
	input  logic [fsme_pkg::FIELD_BITS-1:0]     from_state,
	input  logic [fsme_pkg::FIELD_BITS-1:0]     signal,
	input  logic [fsme_pkg::FIELD_BITS-1:0]     to_state,
	input  fsme_pkg::cfg_load_t                 cfg,
	output logic                                done,
	output logic [fsme_pkg::STATUS_BITS-1:0]    status,
	output logic [fsme_pkg::FIELD_BITS-1:0]     state_now,
	output fsme_pkg::seq_stat_t                 stat
);

	localparam int RAW  = (REGULAR_ENTRIES > 1) ? $clog2(REGULAR_ENTRIES) : 1;
	localparam int EAW  = (ERROR_ENTRIES > 1) ? $clog2(ERROR_ENTRIES) : 1;
	localparam int RCW  = $clog2(REGULAR_ENTRIES + 1);
	localparam int ECW  = $clog2(ERROR_ENTRIES + 1);
	localparam int RW   = 2 * STATE_BITS + SIGNAL_BITS;
	localparam int EW   = STATE_BITS + SIGNAL_BITS;

	fsme_pkg::seq_state_t fsm_q;
	fsme_pkg::status_t    status_q;
	logic                 done_q;
	logic                 pend_q;
	logic [STATE_BITS-1:0]  cur_q;
	logic [SIGNAL_BITS-1:0] sig_q;
	logic [RCW-1:0]       ridx_q;
	logic [ECW-1:0]       eidx_q;
	logic [RCW-1:0]       reg_cnt_q;
	logic [ECW-1:0]       err_cnt_q;

	logic                   accept;
	logic [STATE_BITS-1:0]  from_m;
	logic [SIGNAL_BITS-1:0] sig_m;
	logic [STATE_BITS-1:0]  to_m;
	logic                   reg_full;
	logic                   err_full;
	logic                   reg_we;
	logic                   err_we;
	logic                   reg_re;
	logic                   err_re;
	logic [RW-1:0]          reg_rd;
	logic [EW-1:0]          err_rd;
	logic                   reg_hit;
	logic                   err_hit;

	assign accept   = start && (fsm_q == fsme_pkg::S_IDLE);
	assign from_m   = STATE_BITS'(from_state);
	assign sig_m    = SIGNAL_BITS'(signal);
	assign to_m     = STATE_BITS'(to_state);
	assign reg_full = (reg_cnt_q == RCW'(REGULAR_ENTRIES));
	assign err_full = (err_cnt_q == ECW'(ERROR_ENTRIES));

	assign reg_we = accept && (func == fsme_pkg::FN_ADD_REG) && !reg_full;
	assign err_we = accept && (func == fsme_pkg::FN_ADD_ERR) && !err_full;

	// compare the entry read in the previous cycle
	assign err_hit = pend_q && (fsm_q == fsme_pkg::S_ERR) &&
		(err_rd[EW-1 -: SIGNAL_BITS] == sig_q);
	assign reg_hit = pend_q && (fsm_q == fsme_pkg::S_REG) &&
		(reg_rd[RW-1 -: STATE_BITS] == cur_q) &&
		(reg_rd[EW-1 -: SIGNAL_BITS] == sig_q);

	assign err_re = (fsm_q == fsme_pkg::S_ERR) && !err_hit && (eidx_q < err_cnt_q);
	assign reg_re = (fsm_q == fsme_pkg::S_REG) && !reg_hit && (ridx_q < reg_cnt_q);

	fsme_ram #(.WIDTH(RW), .DEPTH(REGULAR_ENTRIES)) u_reg_ram (
		.clk   (clk),
		.we    (reg_we),
		.waddr (reg_cnt_q[RAW-1:0]),
		.wdata ({from_m, sig_m, to_m}),
		.re    (reg_re),
		.raddr (ridx_q[RAW-1:0]),
		.rdata (reg_rd)
	);

	fsme_ram #(.WIDTH(EW), .DEPTH(ERROR_ENTRIES)) u_err_ram (
		.clk   (clk),
		.we    (err_we),
		.waddr (err_cnt_q[EAW-1:0]),
		.wdata ({sig_m, to_m}),
		.re    (err_re),
		.raddr (eidx_q[EAW-1:0]),
		.rdata (err_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= fsme_pkg::S_IDLE;
			status_q  <= fsme_pkg::ST_OK;
			done_q    <= 1'b0;
			pend_q    <= 1'b0;
			cur_q     <= '0;
			ridx_q    <= '0;
			eidx_q    <= '0;
			reg_cnt_q <= '0;
			err_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg.load) begin
				cur_q <= STATE_BITS'(cfg.value);
			end
			unique case (fsm_q)
				fsme_pkg::S_IDLE: begin
					if (accept) begin
						unique case (func)
							fsme_pkg::FN_ADD_REG: begin
								done_q <= 1'b1;
								if (reg_full) begin
									status_q <= fsme_pkg::ST_FULL;
								end else begin
									status_q  <= fsme_pkg::ST_OK;
									reg_cnt_q <= reg_cnt_q + 1'b1;
								end
							end
							fsme_pkg::FN_ADD_ERR: begin
								done_q <= 1'b1;
								if (err_full) begin
									status_q <= fsme_pkg::ST_FULL;
								end else begin
									status_q  <= fsme_pkg::ST_OK;
									err_cnt_q <= err_cnt_q + 1'b1;
								end
							end
							fsme_pkg::FN_DELIVER: begin
								eidx_q <= '0;
								pend_q <= 1'b0;
								fsm_q  <= fsme_pkg::S_ERR;
							end
							default: begin
								// unused code: plain ok beat
								done_q   <= 1'b1;
								status_q <= fsme_pkg::ST_OK;
							end
						endcase
					end
				end
				fsme_pkg::S_ERR: begin
					if (err_hit) begin
						cur_q    <= err_rd[STATE_BITS-1:0];
						done_q   <= 1'b1;
						status_q <= fsme_pkg::ST_OK;
						pend_q   <= 1'b0;
						fsm_q    <= fsme_pkg::S_IDLE;
					end else if (err_re) begin
						eidx_q <= eidx_q + 1'b1;
						pend_q <= 1'b1;
					end else begin
						ridx_q <= '0;
						pend_q <= 1'b0;
						fsm_q  <= fsme_pkg::S_REG;
					end
				end
				fsme_pkg::S_REG: begin
					if (reg_hit) begin
						cur_q    <= reg_rd[STATE_BITS-1:0];
						done_q   <= 1'b1;
						status_q <= fsme_pkg::ST_OK;
						pend_q   <= 1'b0;
						fsm_q    <= fsme_pkg::S_IDLE;
					end else if (reg_re) begin
						ridx_q <= ridx_q + 1'b1;
						pend_q <= 1'b1;
					end else begin
						done_q   <= 1'b1;
						status_q <= fsme_pkg::ST_NOMATCH;
						pend_q   <= 1'b0;
						fsm_q    <= fsme_pkg::S_IDLE;
					end
				end
				default: begin
					fsm_q <= fsme_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (func == fsme_pkg::FN_DELIVER)) begin
			sig_q <= sig_m;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign state_now = fsme_pkg::FIELD_BITS'(cur_q);

	assign stat.busy     = (fsm_q != fsme_pkg::S_IDLE);
	assign stat.reg_full = reg_full;
	assign stat.err_full = err_full;

endmodule

// ===== hw/rtl/table_driven_fsm_engine_core.sv =====
// top level of the table-driven state machine engine: apb register and sequencer
`timescale 1ns / 1ps

// channel   | signals                                   | beat taken when
// ----------+-------------------------------------------+-------------------------------
// command   | start, busy, func, from_state, signal,    | start high and busy low
//           | to_state                                  |
// result    | done, status, state_now                   | edge that ends the done cycle
// config    | psel, penable, pwrite, paddr, pwdata,     | psel, penable, pwrite, pready
//           | prdata, pready                            |
//
// an add or unused command gives its result beat in the cycle after it is taken,
// and busy stays low, so a new command can be taken in that same cycle
// a deliver scans the error table then the regular table, one ram read a cycle;
// its result beat comes at the first match, or once both tables are scanned without one;
// busy is high until the result beat
// reset clears both fill counts and loads state 0; the tables need no clearing
// the result side cannot stall: each result is shown for exactly one cycle

module table_driven_fsm_engine_core #(
	parameter int STATE_BITS      = fsme_pkg::DEF_STATE_BITS,
	parameter int SIGNAL_BITS     = fsme_pkg::DEF_SIGNAL_BITS,
	parameter int REGULAR_ENTRIES = fsme_pkg::DEF_REGULAR_ENTRIES,
	parameter int ERROR_ENTRIES   = fsme_pkg::DEF_ERROR_ENTRIES
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// command channel
	input  logic                                  start,
	output logic                                  busy,
	input  logic [fsme_pkg::FUNC_BITS-1:0]        func,
	input  logic [fsme_pkg::FIELD_BITS-1:0]       from_state,
	input  logic [fsme_pkg::FIELD_BITS-1:0]       signal,
	input  logic [fsme_pkg::FIELD_BITS-1:0]       to_state,
	// result channel
	output logic                                  done,
	output logic [fsme_pkg::STATUS_BITS-1:0]      status,
	output logic [fsme_pkg::FIELD_BITS-1:0]       state_now,
	// configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fsme_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [fsme_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [fsme_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                  pready
);

	logic [fsme_pkg::FIELD_BITS-1:0] init_q;
	logic                            cfg_wr;
	fsme_pkg::cfg_load_t             cfg;
	fsme_pkg::seq_stat_t             stat;

	assign pready = 1'b1;

	// write completes in the access cycle; paddr[2] picks the register
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == fsme_pkg::REG_INITIAL_STATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
		end else if (cfg_wr) begin
			init_q <= pwdata[fsme_pkg::FIELD_BITS-1:0];
		end
	end

	// writing initial_state also reloads the current state
	assign cfg.load  = cfg_wr;
	assign cfg.value = pwdata[fsme_pkg::FIELD_BITS-1:0];

	assign prdata = (paddr[2] == fsme_pkg::REG_INITIAL_STATE) ?
		fsme_pkg::APB_DATA_BITS'(init_q) : '0;

	fsme_seq #(
		.STATE_BITS      (STATE_BITS),
		.SIGNAL_BITS     (SIGNAL_BITS),
		.REGULAR_ENTRIES (REGULAR_ENTRIES),
		.ERROR_ENTRIES   (ERROR_ENTRIES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func       (func),
		.from_state (from_state),
		.signal     (signal),
		.to_state   (to_state),
		.cfg        (cfg),
		.done       (done),
		.status     (status),
		.state_now  (state_now),
		.stat       (stat)
	);

	assign busy = stat.busy;

	// a scan always ends with its result beat
	a_scan_ends_in_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan ended without a result beat");

	// a full report only follows a command taken in the previous cycle
	a_full_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == fsme_pkg::ST_FULL)) |-> $past(start && !busy))
		else $error("table full reported without a preceding add");

	// tables only grow until reset
	a_reg_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(stat.reg_full) |-> stat.reg_full)
		else $error("regular table fill count went down");

	a_err_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(stat.err_full) |-> stat.err_full)
		else $error("error table fill count went down");

endmodule

// ===== test/table_driven_fsm_engine_core_test.sv =====
// self-checking testbench of the table-driven state machine engine core
`timescale 1ns / 1ps

module table_driven_fsm_engine_core_test;
	import fsme_pkg::*;

	localparam int REG_DEPTH       = DEF_REGULAR_ENTRIES;
	localparam int ERR_DEPTH       = DEF_ERROR_ENTRIES;
	localparam int RANDOM_PHASES   = 5;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int MAX_GAP         = 12;
	// longest deliver scan plus margin
	localparam int DRAIN_CYCLES    = REG_DEPTH + ERR_DEPTH + 20;

	localparam logic [FUNC_BITS-1:0]     FN_UNUSED          = 2'd3;
	localparam logic [APB_ADDR_BITS-1:0] ADDR_INITIAL_STATE = {REG_INITIAL_STATE, 2'b00};
	localparam logic [FIELD_BITS-1:0]    TAIL_STATE         = 8'hA5;

	typedef logic [FIELD_BITS-1:0] field_t;

	// regular transition: source state, signal, destination
	typedef struct packed {
		field_t from;
		field_t sig;
		field_t to;
	} rule_t;

	// error transition: signal, destination
	typedef struct packed {
		field_t sig;
		field_t to;
	} trap_t;

	typedef struct packed {
		status_t st;
		field_t  state;
	} outcome_t;

	// one stimulus row; typed rows carry their result, the rest use the predictor
	typedef struct packed {
		logic [FUNC_BITS-1:0] fn;
		field_t               from;
		field_t               sig;
		field_t               to;
		bit                   typed;
		outcome_t             want;
	} stim_row_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	logic [FUNC_BITS-1:0]     func       = '0;
	field_t                   from_state = '0;
	field_t                   signal     = '0;
	field_t                   to_state   = '0;
	logic                     psel       = 1'b0;
	logic                     penable    = 1'b0;
	logic                     pwrite     = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr      = '0;
	logic [APB_DATA_BITS-1:0] pwdata     = '0;
	logic                     busy;
	logic                     done;
	logic [STATUS_BITS-1:0]   status;
	field_t                   state_now;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	// predictor copy of the machine
	rule_t    rule_tab [REG_DEPTH];
	trap_t    trap_tab [ERR_DEPTH];
	int       rule_fill = 0;
	int       trap_fill = 0;
	field_t   cur_state = '0;
	outcome_t awaited_results [$];
	int       fault_count = 0;

	// directed opening, starting from the reset state 0
	stim_row_t opening_rows [17] = '{
		'{FN_DELIVER, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_NOMATCH, 8'h00}}, // empty tables
		'{FN_UNUSED,  8'hFF, 8'hFF, 8'hFF, 1'b1, '{ST_OK, 8'h00}},      // ignored code
		'{FN_ADD_REG, 8'h00, 8'hFF, 8'hFF, 1'b1, '{ST_OK, 8'h00}},
		'{FN_DELIVER, 8'h00, 8'hFF, 8'h00, 1'b1, '{ST_OK, 8'hFF}},
		'{FN_ADD_REG, 8'hFF, 8'h00, 8'h00, 1'b1, '{ST_OK, 8'hFF}},
		'{FN_ADD_REG, 8'hFF, 8'h00, 8'h55, 1'b0, '{ST_OK, 8'h00}},      // later duplicate
		'{FN_DELIVER, 8'h00, 8'h00, 8'h00, 1'b0, '{ST_OK, 8'h00}},      // earliest wins
		'{FN_ADD_ERR, 8'h00, 8'hAA, 8'h81, 1'b0, '{ST_OK, 8'h00}},
		'{FN_ADD_REG, 8'h00, 8'hAA, 8'h11, 1'b0, '{ST_OK, 8'h00}},
		'{FN_DELIVER, 8'hFF, 8'hAA, 8'hFF, 1'b0, '{ST_OK, 8'h00}},      // error beats regular
		'{FN_DELIVER, 8'h00, 8'h12, 8'h00, 1'b0, '{ST_OK, 8'h00}},      // no match
		'{FN_ADD_ERR, 8'hFF, 8'hAA, 8'h42, 1'b0, '{ST_OK, 8'h00}},
		'{FN_DELIVER, 8'h00, 8'hAA, 8'h00, 1'b0, '{ST_OK, 8'h00}},
		'{FN_ADD_REG, 8'h81, 8'h5A, 8'h00, 1'b0, '{ST_OK, 8'h00}},
		'{FN_DELIVER, 8'h00, 8'h5A, 8'h00, 1'b0, '{ST_OK, 8'h00}},
		'{FN_UNUSED,  8'h00, 8'h00, 8'h00, 1'b0, '{ST_OK, 8'h00}},
		'{FN_DELIVER, 8'h00, 8'hFF, 8'h00, 1'b0, '{ST_OK, 8'h00}}
	};

	// after both tables are full and the state is loaded with TAIL_STATE
	stim_row_t closing_rows [3] = '{
		'{FN_ADD_REG, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{ST_FULL, TAIL_STATE}},
		'{FN_ADD_ERR, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_FULL, TAIL_STATE}},
		'{FN_UNUSED,  8'hFF, 8'h00, 8'hFF, 1'b1, '{ST_OK, TAIL_STATE}}
	};

	table_driven_fsm_engine_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.from_state (from_state),
		.signal     (signal),
		.to_state   (to_state),
		.done       (done),
		.status     (status),
		.state_now  (state_now),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	// apply one command to the predicted machine and return its result
	function automatic outcome_t advance_machine(logic [FUNC_BITS-1:0] fn, field_t from,
			field_t sig, field_t to);
		outcome_t res;
		bit       hit;
		res.st = ST_OK;
		hit = 1'b0;
		case (fn)
			FN_ADD_REG: begin
				if (rule_fill < REG_DEPTH) begin
					rule_tab[rule_fill] = '{from, sig, to};
					rule_fill++;
				end else begin
					res.st = ST_FULL;
				end
			end
			FN_ADD_ERR: begin
				if (trap_fill < ERR_DEPTH) begin
					trap_tab[trap_fill] = '{sig, to};
					trap_fill++;
				end else begin
					res.st = ST_FULL;
				end
			end
			FN_DELIVER: begin
				// error table first, then regular; earliest entry wins
				for (int i = 0; i < trap_fill && !hit; i++) begin
					if (trap_tab[i].sig == sig) begin
						cur_state = trap_tab[i].to;
						hit = 1'b1;
					end
				end
				for (int i = 0; i < rule_fill && !hit; i++) begin
					if (rule_tab[i].sig == sig && rule_tab[i].from == cur_state) begin
						cur_state = rule_tab[i].to;
						hit = 1'b1;
					end
				end
				if (!hit) res.st = ST_NOMATCH;
			end
			default: ;
		endcase
		res.state = cur_state;
		return res;
	endfunction

	// mostly a narrow pool so transitions chain, sometimes the full range
	function automatic field_t pool_or_wide(int lo, int hi, int wide_pct);
		if ($urandom_range(0, 99) < wide_pct) return field_t'($urandom_range(0, 255));
		return field_t'($urandom_range(lo, hi));
	endfunction

	// present one command beat after an idle gap; called and left at a falling edge
	task automatic issue(logic [FUNC_BITS-1:0] fn, field_t from, field_t sig, field_t to,
			int gap, bit typed, outcome_t typed_want);
		outcome_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start      <= 1'b1;
		func       <= fn;
		from_state <= from;
		signal     <= sig;
		to_state   <= to;
		do @(posedge clk); while (busy);
		predicted = advance_machine(fn, from, sig, to);
		awaited_results.insert(awaited_results.size(), typed ? typed_want : predicted);
		@(negedge clk);
	endtask

	task automatic random_item(int gap);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			issue(FN_ADD_REG, pool_or_wide(0, 7, 20), pool_or_wide(0, 7, 20),
				pool_or_wide(0, 7, 20), gap, 1'b0, '0);
		end else if (pick < 30) begin
			// error signals mostly kept apart from regular ones so both tables stay reachable
			issue(FN_ADD_ERR, pool_or_wide(0, 0, 100), pool_or_wide(8, 11, 30),
				pool_or_wide(0, 7, 20), gap, 1'b0, '0);
		end else if (pick < 93) begin
			issue(FN_DELIVER, pool_or_wide(0, 0, 100), pool_or_wide(0, 11, 15),
				pool_or_wide(0, 0, 100), gap, 1'b0, '0);
		end else begin
			issue(FN_UNUSED, pool_or_wide(0, 0, 100), pool_or_wide(0, 0, 100),
				pool_or_wide(0, 0, 100), gap, 1'b0, '0);
		end
	endtask

	// setup then access phase; called and left at a falling edge
	task automatic apb_cycle(bit wr, logic [APB_ADDR_BITS-1:0] addr,
			logic [APB_DATA_BITS-1:0] wdata, output logic [APB_DATA_BITS-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_initial_readback(field_t want);
		logic [APB_DATA_BITS-1:0] rd;
		apb_cycle(1'b0, ADDR_INITIAL_STATE, '0, rd);
		if (rd !== APB_DATA_BITS'(want)) begin
			$error("initial_state readback: expected %0h, got %0h", want, rd);
			fault_count++;
		end
	endtask

	// wait for the block to go idle, then load a new initial state
	task automatic load_initial_state(field_t value);
		logic [APB_DATA_BITS-1:0] rd;
		start <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		apb_cycle(1'b1, ADDR_INITIAL_STATE, APB_DATA_BITS'(value), rd);
		cur_state = value;
		check_initial_readback(value);
	endtask

	// result beats: compare each against the oldest expectation
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (awaited_results.size() == 0) begin
				$error("result beat with nothing expected: status %0d state_now %0h",
					status, state_now);
				fault_count++;
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					fault_count++;
				end
				if (state_now !== want.state) begin
					$error("state_now: expected %0h, got %0h", want.state, state_now);
					fault_count++;
				end
			end
		end
	end

	initial begin
		field_t cfg_plan [RANDOM_PHASES];
		bit     calm;
		calm = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_initial_readback('0);

		foreach (opening_rows[i])
			issue(opening_rows[i].fn, opening_rows[i].from, opening_rows[i].sig,
				opening_rows[i].to, $urandom_range(0, MAX_GAP), opening_rows[i].typed,
				opening_rows[i].want);

		// extremes first, then values in and out of the working pool
		cfg_plan[0] = 8'hFF;
		cfg_plan[1] = 8'h00;
		cfg_plan[2] = field_t'($urandom_range(0, 7));
		cfg_plan[3] = field_t'($urandom_range(0, 255));
		cfg_plan[4] = field_t'($urandom_range(1, 6));
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_initial_state(cfg_plan[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// alternate stretches of back-to-back beats and random gaps
				if (n % 25 == 0) calm = ($urandom_range(0, 2) == 0);
				random_item(calm ? 0 : $urandom_range(0, MAX_GAP));
			end
		end

		// make sure both tables are full before the closing rows
		while (rule_fill < REG_DEPTH)
			issue(FN_ADD_REG, pool_or_wide(0, 7, 20), pool_or_wide(0, 7, 20),
				pool_or_wide(0, 7, 20), $urandom_range(0, MAX_GAP), 1'b0, '0);
		while (trap_fill < ERR_DEPTH)
			issue(FN_ADD_ERR, pool_or_wide(0, 0, 100), pool_or_wide(8, 11, 30),
				pool_or_wide(0, 7, 20), $urandom_range(0, MAX_GAP), 1'b0, '0);

		load_initial_state(TAIL_STATE);
		foreach (closing_rows[i])
			issue(closing_rows[i].fn, closing_rows[i].from, closing_rows[i].sig,
				closing_rows[i].to, $urandom_range(0, MAX_GAP), closing_rows[i].typed,
				closing_rows[i].want);

		start <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#(10_000_000);
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/fsme_pkg.sv
hw/rtl/fsme_ram.sv
hw/rtl/fsme_seq.sv
hw/rtl/table_driven_fsm_engine_core.sv
test/table_driven_fsm_engine_core_test.sv
